@@ rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Shared codes, stage payload type and saturation helper for the complex
// arithmetic unit (signed Q16.16 operands and results).
// ----------------------------------------------------------------------------
package cau_pkg;

    // Command codes
    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_MUL  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_MAG  = 3'd4;
    localparam logic [2:0] CMD_CONJ = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // One quotient bit and one root bit per iteration stage
    localparam int ITER_STAGES = 33;

    localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
    localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

    // Payload of the iteration stages
    typedef struct packed {
        logic [2:0]  cmd;
        logic        div0;
        logic [31:0] res_r;     // finished result for add, sub, mul, conj
        logic [31:0] res_i;
        logic        res_ov;
        logic        neg_r;     // quotient signs
        logic        neg_i;
        logic        qov_r;     // integer part of quotient too large
        logic        qov_i;
        logic [63:0] dvs;       // divisor |B|^2
        logic [63:0] rem_r;     // partial remainders
        logic [63:0] rem_i;
        logic [32:0] nb_r;      // dividend bits still to shift in
        logic [32:0] nb_i;
        logic [32:0] q_r;       // quotient bits
        logic [32:0] q_i;
        logic [33:0] srem;      // square root remainder
        logic [31:0] sroot;     // square root so far
        logic [65:0] sbits;     // radicand pairs still to shift in
    } iter_t;

    // Saturate to 32 bits; bit 32 of the result flags saturation
    function automatic logic [32:0] sat32(input logic signed [49:0] v);
        logic [32:0] r;
        begin
            if (v > SAT_HI)
                r = {1'b1, 32'h7FFF_FFFF};
            else if (v < SAT_LO)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, v[31:0]};
            return r;
        end
    endfunction

endpackage

@@ rtl/complex_arithmetic_unit_core.sv @@
// Pipeline: 3 front stages, 33 iteration stages and 1 output stage.
// Throughput: one word per cycle while the output is not stalled; every
// stage holds one word and stalls only while the stage after it is full
// and stalled.
// Reset: rst_n clears all valid bits asynchronously; no other state.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add, multiply, subtract, divide, magnitude and conjugate on signed
// Q16.16 operands with rounding, saturation and a status code per result.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_real, a_imag, b_real, b_imag
    input  logic [2:0]   s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // res_real, res_imag
    output logic [1:0]   m_axis_tuser   // status
);
    import cau_pkg::*;

    logic  ch_valid [0:ITER_STAGES];
    logic  ch_ready [0:ITER_STAGES];
    iter_t ch_data  [0:ITER_STAGES];

    logic        out_v_reg;
    logic [31:0] out_r_reg, out_i_reg;
    logic [1:0]  out_st_reg;
    logic [31:0] r_next, i_next;
    logic [1:0]  st_next;
    logic [32:0] qr, qi;
    logic [32:0] root_rnd;
    logic        en_o;
    iter_t       last;

    // Round a quotient, apply its sign and saturate; bit 32 flags saturation
    function automatic logic [32:0] div_part(input logic [32:0] q, input logic neg,
                                             input logic qov);
        logic [32:0] m;
        logic [32:0] r;
        begin
            m = {1'b0, q[32:1]} + {32'd0, q[0]};
            if (qov)
                r = {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
            else if (neg)
            begin
                if (m > 33'h0_8000_0000)
                    r = {1'b1, 32'h8000_0000};
                else
                    r = {1'b0, 32'(-m)};
            end
            else if (m > 33'h0_7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, m[31:0]};
            return r;
        end
    endfunction

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .in_ar     (s_axis_tdata[31:0]),
        .in_ai     (s_axis_tdata[63:32]),
        .in_br     (s_axis_tdata[95:64]),
        .in_bi     (s_axis_tdata[127:96]),
        .out_valid (ch_valid[0]),
        .out_ready (ch_ready[0]),
        .out_data  (ch_data[0])
    );

    // Iteration chain
    for (genvar k = 0; k < ITER_STAGES; k++)
    begin : g_iter
        cau_iter_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ch_valid[k]),
            .in_ready  (ch_ready[k]),
            .in_data   (ch_data[k]),
            .out_valid (ch_valid[k+1]),
            .out_ready (ch_ready[k+1]),
            .out_data  (ch_data[k+1])
        );
    end

    assign en_o                  = !out_v_reg || m_axis_tready;
    assign ch_ready[ITER_STAGES] = en_o;
    assign last                  = ch_data[ITER_STAGES];

    // Final rounding and status
    always_comb
    begin
        qr       = div_part(last.q_r, last.neg_r, last.qov_r);
        qi       = div_part(last.q_i, last.neg_i, last.qov_i);
        root_rnd = {1'b0, last.sroot}
                 + {32'd0, (last.srem > {2'b00, last.sroot})};
        r_next   = '0;
        i_next   = '0;
        st_next  = ST_OK;
        case (last.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_CONJ:
            begin
                r_next  = last.res_r;
                i_next  = last.res_i;
                st_next = last.res_ov ? ST_SAT : ST_OK;
            end
            CMD_DIV:
            begin
                if (last.div0)
                    st_next = ST_DIV0;
                else
                begin
                    r_next  = qr[31:0];
                    i_next  = qi[31:0];
                    st_next = (qr[32] || qi[32]) ? ST_SAT : ST_OK;
                end
            end
            CMD_MAG:
            begin
                if (root_rnd > 33'h0_7FFF_FFFF)
                begin
                    r_next  = 32'h7FFF_FFFF;
                    st_next = ST_SAT;
                end
                else
                    r_next = root_rnd[31:0];
            end
            default:
            begin
                r_next  = '0;
                i_next  = '0;
                st_next = ST_OK;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en_o)
            out_v_reg <= ch_valid[ITER_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en_o && ch_valid[ITER_STAGES])
        begin
            out_r_reg  <= r_next;
            out_i_reg  <= i_next;
            out_st_reg <= st_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {out_i_reg, out_r_reg};
    assign m_axis_tuser  = out_st_reg;

endmodule

@@ rtl/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front
// Three front stages: exact products, sums of products, then saturation of
// the simple results and setup of the divider and square root iterations.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_cmd,
    input  logic signed [31:0]  in_ar,
    input  logic signed [31:0]  in_ai,
    input  logic signed [31:0]  in_br,
    input  logic signed [31:0]  in_bi,
    output logic                out_valid,
    input  logic                out_ready,
    output cau_pkg::iter_t      out_data
);
    import cau_pkg::*;

    logic en1, en2, en3;

    // Stage 1 registers
    logic               v1_reg;
    logic [2:0]         cmd1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [63:0] p_bbr_reg, p_bbi_reg, p_aar_reg, p_aai_reg;
    logic signed [32:0] lin_r1_reg, lin_i1_reg;
    logic signed [32:0] lin_r_next, lin_i_next;

    // Stage 2 registers
    logic               v2_reg;
    logic [2:0]         cmd2_reg;
    logic signed [49:0] mul_r_reg, mul_i_reg;
    logic [63:0]        dvs_reg, s_reg;
    logic signed [64:0] nr_reg, ni_reg;
    logic signed [32:0] lin_r2_reg, lin_i2_reg;
    logic signed [65:0] mr_sum, mi_sum;
    logic [49:0]        mul_r_next, mul_i_next;

    // Stage 3 registers
    logic               v3_reg;
    iter_t              d3_reg;
    iter_t              d3_next;
    logic [32:0]        sat_r, sat_i;
    logic [63:0]        mag_r, mag_i;

    // Per-stage advance, bubbles collapse
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Add, subtract and conjugate are exact at 33 bits
    always_comb
    begin
        case (in_cmd)
            CMD_ADD:
            begin
                lin_r_next = 33'(in_ar) + 33'(in_br);
                lin_i_next = 33'(in_ai) + 33'(in_bi);
            end
            CMD_SUB:
            begin
                lin_r_next = 33'(in_ar) - 33'(in_br);
                lin_i_next = 33'(in_ai) - 33'(in_bi);
            end
            CMD_CONJ:
            begin
                lin_r_next = 33'(in_ar);
                lin_i_next = -33'(in_ai);
            end
            default:
            begin
                lin_r_next = '0;
                lin_i_next = '0;
            end
        endcase
    end

    // Stage 1: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            cmd1_reg   <= in_cmd;
            p_rr_reg   <= in_ar * in_br;
            p_ii_reg   <= in_ai * in_bi;
            p_ri_reg   <= in_ar * in_bi;
            p_ir_reg   <= in_ai * in_br;
            p_bbr_reg  <= in_br * in_br;
            p_bbi_reg  <= in_bi * in_bi;
            p_aar_reg  <= in_ar * in_ar;
            p_aai_reg  <= in_ai * in_ai;
            lin_r1_reg <= lin_r_next;
            lin_i1_reg <= lin_i_next;
        end
    end

    // Stage 2: product sums, multiply rounded to nearest with ties up
    assign mr_sum     = 66'(p_rr_reg) - 66'(p_ii_reg) + 66'sd32768;
    assign mi_sum     = 66'(p_ri_reg) + 66'(p_ir_reg) + 66'sd32768;
    assign mul_r_next = mr_sum[65:16];
    assign mul_i_next = mi_sum[65:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            cmd2_reg   <= cmd1_reg;
            mul_r_reg  <= mul_r_next;
            mul_i_reg  <= mul_i_next;
            dvs_reg    <= $unsigned(p_bbr_reg) + $unsigned(p_bbi_reg);
            s_reg      <= $unsigned(p_aar_reg) + $unsigned(p_aai_reg);
            nr_reg     <= 65'(p_rr_reg) + 65'(p_ii_reg);
            ni_reg     <= 65'(p_ir_reg) - 65'(p_ri_reg);
            lin_r2_reg <= lin_r1_reg;
            lin_i2_reg <= lin_i1_reg;
        end
    end

    // Stage 3: saturate simple results, set up the iterations
    always_comb
    begin
        if (cmd2_reg == CMD_MUL)
        begin
            sat_r = sat32(mul_r_reg);
            sat_i = sat32(mul_i_reg);
        end
        else
        begin
            sat_r = sat32(50'(lin_r2_reg));
            sat_i = sat32(50'(lin_i2_reg));
        end
        mag_r = nr_reg[64] ? 64'(-nr_reg) : nr_reg[63:0];
        mag_i = ni_reg[64] ? 64'(-ni_reg) : ni_reg[63:0];

        d3_next.cmd    = cmd2_reg;
        d3_next.div0   = (cmd2_reg == CMD_DIV) && (dvs_reg == 64'd0);
        d3_next.res_r  = sat_r[31:0];
        d3_next.res_i  = sat_i[31:0];
        d3_next.res_ov = sat_r[32] || sat_i[32];
        d3_next.neg_r  = nr_reg[64];
        d3_next.neg_i  = ni_reg[64];
        d3_next.qov_r  = {16'd0, mag_r} >= {dvs_reg, 16'd0};
        d3_next.qov_i  = {16'd0, mag_i} >= {dvs_reg, 16'd0};
        d3_next.dvs    = dvs_reg;
        d3_next.rem_r  = {16'd0, mag_r[63:16]};
        d3_next.rem_i  = {16'd0, mag_i[63:16]};
        d3_next.nb_r   = {mag_r[15:0], 17'd0};
        d3_next.nb_i   = {mag_i[15:0], 17'd0};
        d3_next.q_r    = '0;
        d3_next.q_i    = '0;
        d3_next.srem   = '0;
        d3_next.sroot  = '0;
        d3_next.sbits  = {2'b00, s_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
            d3_reg <= d3_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

@@ rtl/cau_iter_stage.sv @@
// ----------------------------------------------------------------------------
// cau_iter_stage
// One registered iteration: a restoring division step for the real and the
// imaginary quotient, and one digit of the integer square root.
// ----------------------------------------------------------------------------
module cau_iter_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cau_pkg::iter_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output cau_pkg::iter_t  out_data
);
    import cau_pkg::*;

    logic        v_reg;
    iter_t       d_reg;
    iter_t       d_next;
    logic [64:0] rd_r, rd_i, dvs_x;
    logic        ge_r, ge_i;
    logic [35:0] sr2, trial;
    logic        sge;

    assign in_ready = !v_reg || out_ready;

    // Division and square root steps
    always_comb
    begin
        dvs_x = {1'b0, in_data.dvs};
        rd_r  = {in_data.rem_r, in_data.nb_r[32]};
        rd_i  = {in_data.rem_i, in_data.nb_i[32]};
        ge_r  = rd_r >= dvs_x;
        ge_i  = rd_i >= dvs_x;
        sr2   = {in_data.srem, in_data.sbits[65:64]};
        trial = {2'b00, in_data.sroot, 2'b01};
        sge   = sr2 >= trial;

        d_next       = in_data;
        d_next.rem_r = ge_r ? 64'(rd_r - dvs_x) : rd_r[63:0];
        d_next.rem_i = ge_i ? 64'(rd_i - dvs_x) : rd_i[63:0];
        d_next.nb_r  = {in_data.nb_r[31:0], 1'b0};
        d_next.nb_i  = {in_data.nb_i[31:0], 1'b0};
        d_next.q_r   = {in_data.q_r[31:0], ge_r};
        d_next.q_i   = {in_data.q_i[31:0], ge_i};
        d_next.srem  = sge ? 34'(sr2 - trial) : sr2[33:0];
        d_next.sroot = {in_data.sroot[30:0], sge};
        d_next.sbits = {in_data.sbits[63:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

@@ verif/tb_complex_arithmetic_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit_core
// Self-checking bench for the complex arithmetic unit. A directed table covers
// operand extremes, every command, division by zero, saturation and unused
// commands, then random commands follow. Each output word is checked against
// a fixed-point predictor of the complex result and status, in order.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit_core;
    import cau_pkg::*;

    localparam int NUM_RANDOM  = 2000;
    localparam int PIPE_CYCLES = 37;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
        bit          typed;     // expected result given in the row
        logic [31:0] xr;
        logic [31:0] xi;
        logic [1:0]  xs;
    } cmd_row_t;

    typedef struct {
        logic [31:0] rr;
        logic [31:0] ri;
        logic [1:0]  st;
    } cplx_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // a_real, a_imag, b_real, b_imag
    logic [2:0]   s_axis_tuser;   // command
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // res_real, res_imag
    logic [1:0]   m_axis_tuser;   // status

    cplx_res_t    pending_results[$];
    int           error_count;
    int           result_count;
    int           cycle_count;
    bit           sink_quiet;     // no random stalls on the output
    bit           hold_request;
    bit           hold_active;
    int           cmd_seen[8];
    int           st_seen[4];

    complex_arithmetic_unit_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate a wide value to 32 bits, flag overflow
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit ov);
        if (v > 128'sd2147483647)
        begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sd2147483648)
        begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Floor shift by 16 of an exact sum, ties go up after the half is added
    function automatic logic signed [127:0] round_q32(input logic signed [127:0] v);
        return (v + 128'sd32768) >>> 16;
    endfunction

    // Signed quotient num/den in Q16.16, magnitude rounded half away from zero
    function automatic logic signed [127:0] quot_q16(input logic signed [127:0] num,
                                                    input logic [127:0] den, inout bit ov);
        logic [127:0] mag;
        logic [127:0] q;
        bit           neg;
        neg = num < 0;
        mag = neg ? -num : num;
        if (mag / den >= 128'd65536)
        begin
            ov = 1'b1;
            return neg ? -128'sd2147483648 : 128'sd2147483647;
        end
        q = ((mag << 17) / den + 1) >> 1;
        if (neg)
        begin
            if (q > 128'd2147483648)
            begin
                ov = 1'b1;
                return -128'sd2147483648;
            end
            return -$signed(q);
        end
        if (q > 128'd2147483647)
        begin
            ov = 1'b1;
            return 128'sd2147483647;
        end
        return $signed(q);
    endfunction

    function automatic cplx_res_t predict_complex(input logic [2:0] cmd, input logic [31:0] ar,
                                                  input logic [31:0] ai, input logic [31:0] br,
                                                  input logic [31:0] bi);
        logic signed [127:0] xr, xi, yr, yi;
        logic signed [127:0] qv;
        logic [127:0]        den, s, r;
        bit                  ov;
        cplx_res_t           res;
        xr = $signed(ar);
        xi = $signed(ai);
        yr = $signed(br);
        yi = $signed(bi);
        ov = 1'b0;
        res.rr = '0;
        res.ri = '0;
        res.st = ST_OK;
        case (cmd)
            CMD_ADD:
            begin
                res.rr = clamp32(xr + yr, ov);
                res.ri = clamp32(xi + yi, ov);
            end
            CMD_SUB:
            begin
                res.rr = clamp32(xr - yr, ov);
                res.ri = clamp32(xi - yi, ov);
            end
            CMD_MUL:
            begin
                res.rr = clamp32(round_q32(xr * yr - xi * yi), ov);
                res.ri = clamp32(round_q32(xr * yi + xi * yr), ov);
            end
            CMD_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    res.st = ST_DIV0;
                else
                begin
                    qv     = quot_q16(xr * yr + xi * yi, den, ov);
                    res.rr = clamp32(qv, ov);
                    qv     = quot_q16(xi * yr - xr * yi, den, ov);
                    res.ri = clamp32(qv, ov);
                end
            end
            CMD_MAG:
            begin
                s = xr * xr + xi * xi;
                r = 0;
                // Bitwise integer root of a value up to 2^63
                for (int b = 31; b >= 0; b--)
                    if ((r | (128'd1 << b)) * (r | (128'd1 << b)) <= s)
                        r = r | (128'd1 << b);
                if (s - r * r > r)
                    r = r + 1;
                if (r > 128'd2147483647)
                begin
                    ov = 1'b1;
                    r = 128'd2147483647;
                end
                res.rr = r[31:0];
            end
            CMD_CONJ:
            begin
                res.rr = ar;
                res.ri = clamp32(-xi, ov);
            end
            default:
            begin
            end
        endcase
        if (res.st == ST_OK && ov)
            res.st = ST_SAT;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Random operand biased toward edges and small magnitudes
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word; valid stays high after acceptance until the next word or idle
    task automatic offer_word(input logic [2:0] cmd, input logic [31:0] ar,
                              input logic [31:0] ai, input logic [31:0] br,
                              input logic [31:0] bi, input bit allow_gaps);
        int gap;
        if (allow_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {bi, br, ai, ar};
        pending_results.push_back(predict_complex(cmd, ar, ai, br, bi));
        cmd_seen[cmd]++;
        // Hold until the word is taken
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Output side: random stalls, long hold on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        hold_active = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_active)
            begin
                hold_active = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (120) @(posedge clk);
                hold_active = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!sink_quiet && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Check every accepted output word
    always @(posedge clk)
    begin
        cplx_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("[%0t] output word with no result pending", $time);
            end
            else
            begin
                want = pending_results.pop_front();
                result_count++;
                st_seen[m_axis_tuser]++;
                if (m_axis_tdata[31:0] !== want.rr)
                    report_mismatch("res_real", m_axis_tdata[31:0], want.rr);
                if (m_axis_tdata[63:32] !== want.ri)
                    report_mismatch("res_imag", m_axis_tdata[63:32], want.ri);
                if (m_axis_tuser !== want.st)
                    report_mismatch("status", {30'd0, m_axis_tuser}, {30'd0, want.st});
            end
        end
    end

    // Abort on a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        cmd_row_t   rows[$];
        cplx_res_t  want;
        int         idx;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        error_count = 0;
        result_count = 0;
        cycle_count = 0;
        sink_quiet = 1'b0;
        hold_request = 1'b0;

        // Directed rows: command, ar, ai, br, bi, typed, rr, ri, status
        rows = '{
            '{CMD_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 1,
              32'h0004_0000, 32'h0001_0000, ST_OK},
            '{CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1,
              32'h7FFF_FFFF, 32'h8000_0000, ST_SAT},
            '{CMD_SUB, 32'h0005_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1,
              32'h0003_0000, 32'hFFFE_0000, ST_OK},
            '{CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1,
              32'h8000_0000, 32'h7FFF_FFFF, ST_SAT},
            '{CMD_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 1,
              32'hFFF9_0000, 32'h0016_0000, ST_OK},
            '{CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
              0, 0, 0},
            '{CMD_MUL, 32'h0000_0001, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 0,
              0, 0, 0},
            '{CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 0,
              0, 0, 0},
            '{CMD_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1,
              32'h0, 32'h0, ST_DIV0},
            '{CMD_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 32'h0000_0000, 1,
              32'h0002_0000, 32'h0001_0000, ST_OK},
            '{CMD_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000, 0,
              0, 0, 0},
            '{CMD_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000, 0,
              0, 0, 0},
            '{CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0,
              0, 0, 0},
            '{CMD_MAG, 32'h0003_0000, 32'h0004_0000, 32'h1234_5678, 32'h9ABC_DEF0, 1,
              32'h0005_0000, 32'h0, ST_OK},
            '{CMD_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1,
              32'h7FFF_FFFF, 32'h0, ST_SAT},
            '{CMD_MAG, 32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0, 0, 0, 0, 0},
            '{CMD_CONJ, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
              32'h0001_0000, 32'hFFFE_0000, ST_OK},
            '{CMD_CONJ, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, ST_SAT},
            '{3'd6, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444, 1,
              32'h0, 32'h0, ST_OK},
            '{3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
              32'h0, 32'h0, ST_OK}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed rows also cross-check the predictor
        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                want = predict_complex(rows[i].cmd, rows[i].ar, rows[i].ai,
                                       rows[i].br, rows[i].bi);
                if (want.rr !== rows[i].xr || want.ri !== rows[i].xi ||
                    want.st !== rows[i].xs)
                begin
                    error_count++;
                    $display("directed row %0d: predictor disagrees with table", i);
                end
            end
            offer_word(rows[i].cmd, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi, 1'b1);
        end

        // Pause until everything drains
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);

        // Random commands; long output hold a quarter of the way in, no idling at the end
        for (idx = 0; idx < NUM_RANDOM; idx++)
        begin
            if (idx == NUM_RANDOM / 4)
                hold_request = 1'b1;
            if (idx == NUM_RANDOM / 4 + 200)
                hold_request = 1'b0;
            if (idx == NUM_RANDOM / 2)
            begin
                s_axis_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
            end
            if (idx == NUM_RANDOM * 4 / 5)
                sink_quiet = 1'b1;
            offer_word(3'(($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
                                                       : $urandom_range(0, 5)),
                       pick_operand(), pick_operand(),
                       ($urandom_range(0, 12) == 0) ? 32'h0 : pick_operand(),
                       ($urandom_range(0, 12) == 0) ? 32'h0 : pick_operand(),
                       idx < NUM_RANDOM * 4 / 5);
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (PIPE_CYCLES + 10) @(posedge clk);

        $display("Checked %0d results: add %0d mul %0d sub %0d div %0d mag %0d conj %0d",
                 result_count, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3],
                 cmd_seen[4], cmd_seen[5]);
        $display("Status mix: ok %0d, divide by zero %0d, saturated %0d; %0d mismatches",
                 st_seen[0], st_seen[1], st_seen[2], error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
